/* rtl/mlwmmr_pkg.sv */
// ----------------------------------------------------------------------------
// mlwmmr_pkg
// shared types and constants for the multi-level window min/max/rms block
// ----------------------------------------------------------------------------
package mlwmmr_pkg;

    localparam int NUM_REGS   = 6;
    localparam int REG_IDX_W  = 3;
    localparam int WSIZE_W    = 17;
    localparam int SAMPLE_W   = 24;
    localparam int SQSUM_W    = 63;
    localparam int LEVEL_W    = 3;
    localparam int RMS_W      = 24;

    // one closed window handed from the front part to the back part
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] pmin;
        logic [SAMPLE_W-1:0] pmax;
        logic [SQSUM_W-1:0]  sqsum;
        logic [WSIZE_W-1:0]  count;
        logic                last;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCAN
    } t_front_state;

endpackage

/* rtl/mlwmmr_front.sv */
// ----------------------------------------------------------------------------
// mlwmmr_front
// accepts samples, updates the per-level accumulators one level per cycle
// unless a closing level meets a full job queue; pushes closed windows into it
// ----------------------------------------------------------------------------
module mlwmmr_front #(
    parameter int NUM_LEVELS      = 6,
    parameter int SAMPLE_BITS     = 24,
    parameter int MAX_WINDOW_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mlwmmr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                              i_end_of_buffer,
    input  logic [mlwmmr_pkg::WSIZE_W-1:0]    i_wsize [NUM_LEVELS],
    output logic                              o_push,
    output mlwmmr_pkg::t_job                  o_job,
    input  logic                              i_full
);
    import mlwmmr_pkg::*;

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [WSIZE_W-1:0] TOP = WSIZE_W'(1) << MAX_WINDOW_BITS;

    t_front_state r_st, n_st;
    logic [LW-1:0] r_lvl;
    logic signed [SAMPLE_W-1:0] r_s;
    logic [2*SAMPLE_W-1:0] r_sq;
    logic r_eob;

    logic [SAMPLE_W-1:0] r_min [NUM_LEVELS];
    logic [SAMPLE_W-1:0] r_max [NUM_LEVELS];
    logic [SQSUM_W-1:0]  r_sum [NUM_LEVELS];
    logic [WSIZE_W-1:0]  r_cnt [NUM_LEVELS];

    logic signed [SAMPLE_W-1:0] s_ext;
    logic signed [SAMPLE_W-1:0] c_min, c_max;
    logic [SQSUM_W-1:0] c_sum;
    logic [WSIZE_W-1:0] c_cnt, eff;
    logic close, later, last_lvl;

    // sign-extend the low SAMPLE_BITS bits
    always_comb begin
        s_ext = SAMPLE_W'($signed(i_sample[SAMPLE_BITS-1:0]));
    end

    always_comb begin
        logic empty;
        empty = (r_cnt[r_lvl] == '0);
        c_min = (empty || r_s < $signed(r_min[r_lvl])) ? r_s : $signed(r_min[r_lvl]);
        c_max = (empty || r_s > $signed(r_max[r_lvl])) ? r_s : $signed(r_max[r_lvl]);
        c_sum = (empty ? '0 : r_sum[r_lvl]) + SQSUM_W'(r_sq);
        c_cnt = r_cnt[r_lvl] + 1'b1;
        eff   = i_wsize[r_lvl];
        if (eff == '0) eff = WSIZE_W'(1);
        if (eff > TOP) eff = TOP;
        close = (c_cnt >= eff) || r_eob;
        last_lvl = (r_lvl == LW'(NUM_LEVELS-1));
        // any higher level closing on this sample
        later = r_eob && !last_lvl;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            logic [WSIZE_W-1:0] e;
            e = i_wsize[k];
            if (e == '0) e = WSIZE_W'(1);
            if (e > TOP) e = TOP;
            if (k > int'(r_lvl) && (r_cnt[k] + 1'b1) >= e) later = 1'b1;
        end
    end

    // the queue takes one entry per closing step, which waits while it is full
    logic step;
    assign step = (r_st == FS_SCAN) && !(close && i_full);

    always_comb begin
        n_st = r_st;
        case (r_st)
            FS_IDLE: if (i_valid) n_st = FS_SCAN;
            FS_SCAN: if (step && last_lvl) n_st = FS_IDLE;
            default: n_st = FS_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_st != FS_IDLE);
        o_push        = step && close;
        o_job.level   = LEVEL_W'(r_lvl);
        o_job.pmin    = c_min;
        o_job.pmax    = c_max;
        o_job.sqsum   = c_sum;
        o_job.count   = c_cnt;
        o_job.last    = !later;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= FS_IDLE;
            r_lvl <= '0;
            for (int k = 0; k < NUM_LEVELS; k++) r_cnt[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == FS_IDLE && i_valid) begin
                r_s   <= s_ext;
                r_sq  <= (2*SAMPLE_W)'($signed(s_ext) * $signed(s_ext));
                r_eob <= i_end_of_buffer;
                r_lvl <= '0;
            end
            if (step) begin
                r_min[r_lvl] <= c_min;
                r_max[r_lvl] <= c_max;
                r_sum[r_lvl] <= c_sum;
                r_cnt[r_lvl] <= close ? '0 : c_cnt;
                if (!last_lvl) r_lvl <= r_lvl + 1'b1;
            end
        end
    end
endmodule

/* rtl/mlwmmr_fifo.sv */
// ----------------------------------------------------------------------------
// mlwmmr_fifo
// short job queue between the accumulator front and the divide/sqrt back
// ----------------------------------------------------------------------------
module mlwmmr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mlwmmr_pkg::t_job i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output mlwmmr_pkg::t_job o_job
);
    import mlwmmr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

/* rtl/mlwmmr_back.sv */
// ----------------------------------------------------------------------------
// mlwmmr_back
// restoring divide of the square sum by the count, then a bit-pair square
// root, then the result register
// ----------------------------------------------------------------------------
module mlwmmr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  mlwmmr_pkg::t_job                 i_job,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mlwmmr_pkg::LEVEL_W-1:0]   o_level,
    output logic [mlwmmr_pkg::SAMPLE_W-1:0]  o_point_min,
    output logic [mlwmmr_pkg::SAMPLE_W-1:0]  o_point_max,
    output logic [mlwmmr_pkg::RMS_W-1:0]     o_point_rms,
    output logic [mlwmmr_pkg::WSIZE_W-1:0]   o_point_count,
    output logic                             o_last_of_run
);
    import mlwmmr_pkg::*;

    localparam int QW = 48;      // quotient bounded by max square
    localparam int DSTEP = 2;    // quotient bits per cycle
    localparam int SSTEP = 2;    // root bits per cycle

    t_back_state r_st, n_st;
    t_job r_job;
    logic [QW-1:0] r_q;
    logic [SQSUM_W-1:0] r_rem;
    logic [5:0] r_i;
    logic [QW-1:0] r_v;
    logic [RMS_W:0] r_root;
    logic [RMS_W+2:0] r_srem;
    logic [RMS_W-1:0] r_rms;

    logic [QW-1:0] d_q;
    logic [SQSUM_W-1:0] d_rem;
    logic [RMS_W:0] s_root;
    logic [RMS_W+2:0] s_rem;
    logic [5:0] i_next;
    logic done_sqrt;

    // long division, quotient bits from the top
    always_comb begin
        logic [SQSUM_W:0] t;
        d_q = r_q;
        d_rem = r_rem;
        for (int k = 0; k < DSTEP; k++) begin
            t = {d_rem, r_job.sqsum[SQSUM_W-1 - (int'(r_i) + k)]};
            d_q = {d_q[QW-2:0], 1'b0};
            if (t >= (SQSUM_W+1)'(r_job.count)) begin
                t = t - (SQSUM_W+1)'(r_job.count);
                d_q[0] = 1'b1;
            end
            d_rem = t[SQSUM_W-1:0];
        end
    end

    // digit-by-digit square root of the 48-bit mean
    always_comb begin
        logic [RMS_W+2:0] t;
        logic [RMS_W+2:0] trial;
        s_root = r_root;
        s_rem  = r_srem;
        for (int k = 0; k < SSTEP; k++) begin
            t = {s_rem[RMS_W:0], r_v[QW-1 - 2*(int'(r_i)+k) -: 2]};
            trial = {s_root, 2'b01};
            s_root = {s_root[RMS_W-1:0], 1'b0};
            if (t >= trial) begin
                t = t - trial;
                s_root[0] = 1'b1;
            end
            s_rem = t;
        end
    end

    assign i_next    = r_i + 6'(DSTEP);
    assign done_sqrt = (r_i + 6'(SSTEP) == 6'(QW/2));

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (!i_empty) n_st = ST_DIV;
            ST_DIV:  if (r_i >= 6'(SQSUM_W - DSTEP + 1)) n_st = ST_SQRT;
            ST_SQRT: if (done_sqrt) n_st = ST_OUT;
            ST_OUT:  if (!i_stall) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop         = (r_st == ST_IDLE) && !i_empty;
        o_valid       = (r_st == ST_OUT);
        o_level       = r_job.level;
        o_point_min   = r_job.pmin;
        o_point_max   = r_job.pmax;
        o_point_rms   = r_rms;
        o_point_count = r_job.count;
        o_last_of_run = r_job.last;
    end

    // 63 dividend bits: one single step at the end keeps the pair stepping even
    logic [QW-1:0] d1_q;
    logic [SQSUM_W-1:0] d1_rem;
    always_comb begin
        logic [SQSUM_W:0] t;
        t = {r_rem, r_job.sqsum[0]};
        d1_q = {r_q[QW-2:0], 1'b0};
        if (t >= (SQSUM_W+1)'(r_job.count)) begin
            t = t - (SQSUM_W+1)'(r_job.count);
            d1_q[0] = 1'b1;
        end
        d1_rem = t[SQSUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
        case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_q   <= '0;
                r_rem <= '0;
                r_i   <= '0;
            end
            ST_DIV: begin
                if (r_i >= 6'(SQSUM_W - DSTEP + 1)) begin
                    r_v    <= d1_q;
                    r_i    <= '0;
                    r_root <= '0;
                    r_srem <= '0;
                end else begin
                    r_q   <= d_q;
                    r_rem <= d_rem;
                    r_i   <= i_next;
                end
            end
            ST_SQRT: begin
                r_root <= s_root;
                r_srem <= s_rem;
                r_i    <= r_i + 6'(SSTEP);
                if (done_sqrt) r_rms <= s_root[RMS_W-1:0];
            end
            default: ;
        endcase
    end
endmodule

/* rtl/multi_level_window_min_max_rms.sv */
// ----------------------------------------------------------------------------
// multi_level_window_min_max_rms
// six-level min/max/rms waveform decimation of one sample stream
// ----------------------------------------------------------------------------
//  channel  | handshake              | beat
//  in       | i_valid / o_stall      | i_sample, i_end_of_buffer
//  out      | o_valid / i_stall      | level, min, max, rms, count, last
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// the front stalls while scanning a sample, one level per cycle unless a push waits
// each window passes the back as pop, divide, sqrt, out before the next pop
// a result beat held by i_stall holds the back, and a closing level waits on a full queue
// a four-entry job queue lets the front run ahead while results wait
// synchronous active-low reset: counts cleared, window sizes to defaults
module multi_level_window_min_max_rms #(
    parameter int NUM_LEVELS      = 6,
    parameter int SAMPLE_BITS     = 24,
    parameter int MAX_WINDOW_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [mlwmmr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_end_of_buffer,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [mlwmmr_pkg::LEVEL_W-1:0]     o_level,
    output logic signed [mlwmmr_pkg::SAMPLE_W-1:0] o_point_min,
    output logic signed [mlwmmr_pkg::SAMPLE_W-1:0] o_point_max,
    output logic [mlwmmr_pkg::RMS_W-1:0]       o_point_rms,
    output logic [mlwmmr_pkg::WSIZE_W-1:0]     o_point_count,
    output logic                               o_last_of_run,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mlwmmr_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [mlwmmr_pkg::WSIZE_W-1:0]     i_cfg_data
);
    import mlwmmr_pkg::*;

    logic [WSIZE_W-1:0] r_wsize [NUM_REGS];
    logic [WSIZE_W-1:0] wsz [NUM_LEVELS];
    logic push, full, pop, empty;
    t_job fjob, qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++)
                r_wsize[k] <= WSIZE_W'(4) << (2*k);
        end else if (i_cfg_valid && i_cfg_index < REG_IDX_W'(NUM_REGS)) begin
            r_wsize[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_LEVELS; k++) wsz[k] = r_wsize[k];
    end

    mlwmmr_front #(
        .NUM_LEVELS(NUM_LEVELS), .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_WINDOW_BITS(MAX_WINDOW_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .i_end_of_buffer(i_end_of_buffer), .i_wsize(wsz),
        .o_push(push), .o_job(fjob), .i_full(full)
    );

    mlwmmr_fifo #(.DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_job(qjob)
    );

    mlwmmr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(qjob),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_level(o_level),
        .o_point_min(o_point_min), .o_point_max(o_point_max),
        .o_point_rms(o_point_rms), .o_point_count(o_point_count),
        .o_last_of_run(o_last_of_run)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("push into full queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_rms))
        else $error("result dropped under stall");
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_point_count != '0) else $error("empty window emitted");
endmodule
